FILE: rtl/core/itp_pkg.sv
// itp_pkg: types, character constants and helpers for the ini text packer
// used by ini_text_packer_unit; no dependencies

package itp_pkg;

  // widths of the saturating counters and of the report fields
  localparam int LINE_BITS   = 16;
  localparam int LENGTH_BITS = 16;
  localparam int REPORT_BITS = 16;

  // characters of interest
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_RBRACK  = 8'h5D;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  // input mode codes
  typedef enum logic {
    MODE_TEXT = 1'b0,
    MODE_END  = 1'b1
  } mode_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // syntax error codes
  typedef enum logic [2:0] {
    ERR_UNMATCHED  = 3'd0,
    ERR_NO_VALUE   = 3'd1,
    ERR_NO_EQ      = 3'd2,
    ERR_NO_SECNAME = 3'd3,
    ERR_NO_SECEND  = 3'd4,
    ERR_JUNK       = 3'd5
  } err_code_t;

  // line parser states
  typedef enum logic [3:0] {
    ST_LINE_START,
    ST_SEC_FIRST,
    ST_SEC_NAME,
    ST_KEY,
    ST_EQ,
    ST_VALUE,
    ST_LINE_END,
    ST_SKIP,
    ST_ERROR
  } parse_state_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_white(input logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic logic is_comment(input logic [7:0] c);
    return (c == CH_HASH) || (c == CH_SEMI);
  endfunction

  // clamp a counter value to the report width
  function automatic logic [REPORT_BITS-1:0] cap_report(input logic [31:0] v);
    logic [31:0] lim;
    lim = 32'((64'd1 << REPORT_BITS) - 64'd1);
    return (v > lim) ? '1 : v[REPORT_BITS-1:0];
  endfunction

endpackage

FILE: rtl/core/ini_text_packer_unit.sv
// ini_text_packer_unit: streaming packer and syntax checker for ini style text
// depends on itp_pkg (types, character constants, helper functions)
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------------
//  input   | in_valid/in_stall  | mode, text_byte
//  output  | out_valid/out_stall| kind, packed_byte, error_code, line_number,
//          |                    | packed_length
//
// one input transaction per cycle while the input is not stalled; a transaction that
// yields a result loads it into the result register, where it shows in the next cycle
// the parser state and counters update in the same cycle a transaction is taken
// rst (synchronous) returns the parser to line start, line count one, length zero
// input stalls only while the result register is full and the output stalls

module ini_text_packer_unit import itp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [7:0]             text_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             kind,
  output logic [7:0]             packed_byte,
  output logic [2:0]             error_code,
  output logic [REPORT_BITS-1:0] line_number,
  output logic [REPORT_BITS-1:0] packed_length
);

  parse_state_t           state, state_next;
  err_code_t              err, err_next;
  logic                   inside_quotes, inside_quotes_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [LENGTH_BITS-1:0] out_count, out_count_next;

  logic       in_take;
  logic       res_valid;
  kind_t      res_kind;
  logic [7:0] res_byte;
  err_code_t  res_code;
  logic [REPORT_BITS-1:0] res_line;
  logic [REPORT_BITS-1:0] res_len;

  // result register frees when empty or drained
  assign in_stall = out_valid && out_stall;
  assign in_take  = in_valid && !in_stall;

  // parser next state and result
  always_comb begin
    logic       quote_flip;
    logic       keep;
    logic       emit;
    logic       new_line;
    logic [7:0] pb;

    quote_flip = (text_byte == CH_QUOTE);
    keep       = 1'b0;
    emit       = 1'b0;
    new_line   = 1'b0;
    pb         = CH_NUL;

    state_next         = state;
    err_next           = err;
    inside_quotes_next = inside_quotes;
    line_count_next    = line_count;
    out_count_next     = out_count;

    res_valid = 1'b0;
    res_kind  = KIND_BYTE;
    res_byte  = CH_NUL;
    res_code  = ERR_UNMATCHED;
    res_line  = '0;
    res_len   = '0;

    if (mode == MODE_END) begin
      // end of text: report and return to reset
      res_valid = 1'b1;
      res_kind  = KIND_ERROR;
      res_line  = cap_report(32'(line_count));
      unique case (state)
        ST_SEC_FIRST: res_code = ERR_NO_SECNAME;
        ST_SEC_NAME:  res_code = ERR_NO_SECEND;
        ST_KEY:       res_code = ERR_NO_EQ;
        ST_EQ:        res_code = ERR_NO_VALUE;
        ST_VALUE:     res_code = ERR_UNMATCHED;
        ST_ERROR:     res_code = err;
        default: begin
          res_kind = KIND_DONE;
          res_line = '0;
          res_len  = cap_report(32'(out_count));
        end
      endcase
      state_next         = ST_LINE_START;
      err_next           = ERR_UNMATCHED;
      inside_quotes_next = 1'b0;
      line_count_next    = LINE_BITS'(1);
      out_count_next     = '0;
    end else begin
      // quote toggle and whitespace filter
      inside_quotes_next = inside_quotes ^ quote_flip;
      keep = inside_quotes_next || !is_white(text_byte) || (text_byte == CH_NEWLINE);
      if (keep && (state != ST_ERROR)) begin
        unique case (state)
          ST_LINE_START: begin
            if (text_byte == CH_LBRACK) begin
              emit = 1'b1; pb = text_byte; state_next = ST_SEC_FIRST;
            end else if (is_letter(text_byte)) begin
              emit = 1'b1; pb = text_byte; state_next = ST_KEY;
            end else if (text_byte == CH_NEWLINE) begin
              new_line = 1'b1;
            end else if (is_comment(text_byte)) begin
              state_next = ST_SKIP;
            end else begin
              state_next = ST_ERROR; err_next = ERR_JUNK;
            end
          end
          ST_SEC_FIRST: begin
            if (is_letter(text_byte)) begin
              emit = 1'b1; pb = text_byte; state_next = ST_SEC_NAME;
            end else begin
              state_next = ST_ERROR; err_next = ERR_NO_SECNAME;
            end
          end
          ST_SEC_NAME: begin
            if (is_letter(text_byte)) begin
              emit = 1'b1; pb = text_byte;
            end else if (text_byte == CH_RBRACK) begin
              emit = 1'b1; state_next = ST_LINE_END;
            end else begin
              state_next = ST_ERROR; err_next = ERR_NO_SECEND;
            end
          end
          ST_KEY: begin
            if (is_letter(text_byte)) begin
              emit = 1'b1; pb = text_byte;
            end else if (text_byte == CH_EQUAL) begin
              state_next = ST_EQ;
            end else begin
              state_next = ST_ERROR; err_next = ERR_NO_EQ;
            end
          end
          ST_EQ: begin
            if (text_byte == CH_QUOTE) begin
              emit = 1'b1; state_next = ST_VALUE;
            end else begin
              state_next = ST_ERROR; err_next = ERR_NO_VALUE;
            end
          end
          ST_VALUE: begin
            if (text_byte == CH_QUOTE) begin
              emit = 1'b1; state_next = ST_LINE_END;
            end else if ((text_byte == CH_NEWLINE) || (text_byte == CH_NUL)) begin
              state_next = ST_ERROR; err_next = ERR_UNMATCHED;
            end else begin
              emit = 1'b1; pb = text_byte;
            end
          end
          ST_LINE_END: begin
            if (is_comment(text_byte)) begin
              state_next = ST_SKIP;
            end else if (text_byte == CH_NEWLINE) begin
              new_line = 1'b1;
            end else begin
              state_next = ST_ERROR; err_next = ERR_JUNK;
            end
          end
          ST_SKIP: begin
            if (text_byte == CH_NEWLINE) begin
              new_line = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      // saturating line and length counters
      if (new_line) begin
        state_next = ST_LINE_START;
        if (line_count != '1) begin
          line_count_next = line_count + LINE_BITS'(1);
        end
      end
      if (emit) begin
        if (out_count != '1) begin
          out_count_next = out_count + LENGTH_BITS'(1);
        end
        res_valid = 1'b1;
        res_kind  = KIND_BYTE;
        res_byte  = pb;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_LINE_START;
      err           <= ERR_UNMATCHED;
      inside_quotes <= 1'b0;
      line_count    <= LINE_BITS'(1);
      out_count     <= '0;
    end else if (in_take) begin
      state         <= state_next;
      err           <= err_next;
      inside_quotes <= inside_quotes_next;
      line_count    <= line_count_next;
      out_count     <= out_count_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_take && res_valid) begin
      kind          <= res_kind;
      packed_byte   <= res_byte;
      error_code    <= res_code;
      line_number   <= res_line;
      packed_length <= res_len;
    end
  end

`ifndef SYNTHESIS
  // an end marker always yields a final report
  assert property (@(posedge clk) disable iff (rst)
    (in_take && (mode == MODE_END)) |=>
      (out_valid && ((kind == KIND_DONE) || (kind == KIND_ERROR))))
    else $error("end marker gave no final report");

  // an end marker returns the parser to its reset condition
  assert property (@(posedge clk) disable iff (rst)
    (in_take && (mode == MODE_END)) |=>
      ((state == ST_LINE_START) && (line_count == LINE_BITS'(1)) &&
       (out_count == '0) && !inside_quotes))
    else $error("parser not cleared after end marker");

  // text after an error emits nothing
  assert property (@(posedge clk) disable iff (rst)
    (in_take && (mode == MODE_TEXT) && (state == ST_ERROR)) |=> !out_valid)
    else $error("output produced after syntax error");

  // packed length only grows while parsing text
  assert property (@(posedge clk) disable iff (rst)
    (in_take && (mode == MODE_TEXT)) |=> (out_count >= $past(out_count)))
    else $error("packed length went backward");
`endif

endmodule
